// ===== hdl/rgbsh_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the rgb sharpen filter
package rgbsh_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT_DEF  = 2048;
    localparam int CFG_W           = 12;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int OUT_QUEUE_DEPTH = 4;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef logic [7:0] chan_t;

    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_pair_t;

    typedef struct packed {
        logic   last;
        pixel_t pix;
    } out_item_t;

endpackage

// ===== hdl/rgb_sharpen_3x3_filter.sv =====
`timescale 1ns / 1ps
// rgb 3x3 sharpen filter top level: line store, window, kernel and control
// path: a request passes the stage 1 and stage 2 registers and the output queue before its result shows on m_tvalid
// throughput: one request per cycle while s_tready is high; the line store takes one read and one write a cycle
// output pixel q leaves with input pixel q+width+1, the tail with flush requests
// reset: size registers 640 x 480, position counters and pipeline cleared
// the line store is not cleared; entries not yet written by the current image feed only edge outputs, which ignore them
module rgb_sharpen_3x3_filter import rgbsh_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // red, green, blue
    input  logic              s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // out_red, out_green, out_blue
    output logic              m_tlast    // last_pixel
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int GAP_W = $clog2(MAX_WIDTH + 3);
    localparam int CNT_W = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int RST_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    // size and position state
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic             in_done_reg, in_done_next;

    logic             accept;
    logic             act_pixel;
    logic             act_flush;
    logic             gap_full;
    logic             emit;
    logic             out_last;
    logic             out_edge;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [31:0]      cfg_val32;
    logic [COL_W-1:0] cfg_w_m1;
    logic [ROW_W-1:0] cfg_h_m1;

    // line store and stage 1
    line_pair_t       line_mem [MAX_WIDTH];
    line_pair_t       rdata_reg;
    line_pair_t       fwd_data_reg;
    logic             fwd_reg;
    line_pair_t       line_pair;
    line_pair_t       wr_pair;

    logic             s1_pix_vld_reg;
    logic             s1_out_vld_reg;
    logic             s1_flush_reg;
    logic             s1_edge_reg;
    logic             s1_last_reg;
    logic             s1_sel_lo_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_pix_reg;

    pixel_t           win_top_reg;
    pixel_t           win_mid_reg;
    pixel_t           win_bot_reg;
    pixel_t           win_west_reg;
    pixel_t           center;

    // stage 2
    logic             s2_vld_reg;
    logic             s2_last_reg;
    logic [2:0][10:0] s2_pos_reg;
    logic [2:0][9:0]  s2_neg_reg;
    logic [2:0][10:0] pos_next;
    logic [2:0][9:0]  neg_next;

    out_item_t        res_item;
    out_item_t        m_item;
    logic [CNT_W-1:0] queue_count;
    logic [CNT_W:0]   busy;

    // request decode
    assign accept    = s_tvalid && s_tready;
    assign act_pixel = accept && (s_tuser == KIND_PIXEL) && !in_done_reg;
    assign act_flush = accept && !act_pixel && in_done_reg && (gap_reg != '0);
    assign gap_full  = (gap_reg >= (GAP_W'(w_m1_reg) + GAP_W'(2)));
    assign emit      = act_flush || (act_pixel && gap_full);
    assign out_last  = (out_row_reg == h_m1_reg) && (out_col_reg == w_m1_reg);
    assign out_edge  = (out_row_reg == '0) || (out_row_reg == h_m1_reg) ||
                       (out_col_reg == '0) || (out_col_reg == w_m1_reg);
    assign rd_en     = act_pixel || act_flush;
    assign rd_addr   = act_pixel ? in_col_reg : out_col_reg;

    // size register clamp
    assign cfg_val32 = 32'(cfg_wdata);

    always_comb begin
        if (cfg_val32 == 32'd0) begin
            cfg_w_m1 = '0;
        end else if (cfg_val32 > 32'(MAX_WIDTH)) begin
            cfg_w_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_w_m1 = COL_W'(cfg_val32 - 32'd1);
        end
        if (cfg_val32 == 32'd0) begin
            cfg_h_m1 = '0;
        end else if (cfg_val32 > 32'(MAX_HEIGHT)) begin
            cfg_h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            cfg_h_m1 = ROW_W'(cfg_val32 - 32'd1);
        end
    end

    always_comb begin
        w_m1_next    = w_m1_reg;
        h_m1_next    = h_m1_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        gap_next     = gap_reg;
        in_done_next = in_done_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH: begin
                    w_m1_next = cfg_w_m1;
                end
                REG_IMAGE_HEIGHT: begin
                    h_m1_next = cfg_h_m1;
                end
                default: begin
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            gap_next     = '0;
            in_done_next = 1'b0;
        end else begin
            if (act_pixel) begin
                if (in_col_reg == w_m1_reg) begin
                    in_col_next = '0;
                    if (in_row_reg == h_m1_reg) begin
                        in_done_next = 1'b1;
                    end else begin
                        in_row_next = in_row_reg + ROW_W'(1);
                    end
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (!gap_full) begin
                    gap_next = gap_reg + GAP_W'(1);
                end
            end
            if (act_flush) begin
                gap_next = gap_reg - GAP_W'(1);
            end
            if (emit) begin
                if (out_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    gap_next     = '0;
                    in_done_next = 1'b0;
                end else if (out_col_reg == w_m1_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_m1_reg    <= COL_W'(RST_W - 1);
            h_m1_reg    <= ROW_W'(RST_H - 1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            gap_reg     <= '0;
            in_done_reg <= 1'b0;
        end else begin
            w_m1_reg    <= w_m1_next;
            h_m1_reg    <= h_m1_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            gap_reg     <= gap_next;
            in_done_reg <= in_done_next;
        end
    end

    // line store: upper holds the row above, lower the newest row
    assign line_pair = fwd_reg ? fwd_data_reg : rdata_reg;
    assign wr_pair   = '{upper: line_pair.lower, lower: s1_pix_reg};

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= line_mem[rd_addr];
        end
        if (s1_pix_vld_reg) begin
            line_mem[s1_col_reg] <= wr_pair;
        end
    end

    // write-to-read forwarding on the same column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= s1_pix_vld_reg && rd_en && (rd_addr == s1_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_pair;
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_pix_vld_reg <= 1'b0;
            s1_out_vld_reg <= 1'b0;
        end else begin
            s1_pix_vld_reg <= act_pixel;
            s1_out_vld_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_flush_reg  <= act_flush;
        s1_edge_reg   <= out_edge;
        s1_last_reg   <= out_last;
        s1_sel_lo_reg <= (out_row_reg == h_m1_reg);
        s1_col_reg    <= in_col_reg;
        s1_pix_reg    <= pixel_t'(s_tdata);
    end

    // window: column of the previous pixel and the middle of the one before
    always_ff @(posedge aclk) begin
        if (s1_pix_vld_reg) begin
            win_top_reg  <= line_pair.upper;
            win_mid_reg  <= line_pair.lower;
            win_bot_reg  <= s1_pix_reg;
            win_west_reg <= win_mid_reg;
        end
    end

    // kernel, first half: five times center and the neighbor sum; on edges the center alone
    always_comb begin
        if (s1_flush_reg) begin
            center = s1_sel_lo_reg ? line_pair.lower : line_pair.upper;
        end else begin
            center = win_mid_reg;
        end
        for (int k = 0; k < 3; k++) begin
            if (s1_edge_reg) begin
                pos_next[k] = {3'b000, center[8*k +: 8]};
                neg_next[k] = '0;
            end else begin
                pos_next[k] = {1'b0, center[8*k +: 8], 2'b00} + {3'b000, center[8*k +: 8]};
                neg_next[k] = {2'b00, win_top_reg[8*k +: 8]} +
                              {2'b00, win_bot_reg[8*k +: 8]} +
                              {2'b00, win_west_reg[8*k +: 8]} +
                              {2'b00, line_pair.lower[8*k +: 8]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else begin
            s2_vld_reg <= s1_out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_last_reg <= s1_last_reg;
        s2_pos_reg  <= pos_next;
        s2_neg_reg  <= neg_next;
    end

    // kernel, second half: difference and clamp to 0..255
    always_comb begin
        logic [11:0] diff;
        logic [23:0] data;
        data = '0;
        for (int k = 0; k < 3; k++) begin
            diff = {1'b0, s2_pos_reg[k]} - {2'b00, s2_neg_reg[k]};
            if (diff[11]) begin
                data[8*k +: 8] = 8'd0;
            end else if (diff[10:8] != 3'b000) begin
                data[8*k +: 8] = 8'd255;
            end else begin
                data[8*k +: 8] = diff[7:0];
            end
        end
        res_item.last = s2_last_reg;
        res_item.pix  = pixel_t'(data);
    end

    rgbsh_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s2_vld_reg),
        .wr_item  (res_item),
        .count    (queue_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_item   (m_item)
    );

    // space for every result that may still be in flight
    assign busy     = (CNT_W+1)'(queue_count) + (CNT_W+1)'(s1_out_vld_reg) +
                      (CNT_W+1)'(s2_vld_reg);
    assign s_tready = (busy < (CNT_W+1)'(OUT_QUEUE_DEPTH));

    assign m_tdata = m_item.pix;
    assign m_tlast = m_item.last;

endmodule

// ===== hdl/rgbsh_out_queue.sv =====
`timescale 1ns / 1ps
// small output queue that decouples the filter pipeline from the result channel
module rgbsh_out_queue import rgbsh_pkg::*; (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  out_item_t                             wr_item,
    output logic [$clog2(OUT_QUEUE_DEPTH+1)-1:0]  count,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output out_item_t                             m_item
);

    localparam int PTR_W = $clog2(OUT_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(OUT_QUEUE_DEPTH + 1);

    out_item_t          entry_reg [OUT_QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rd_en;

    assign rd_en    = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_item   = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            if (wr_ptr_reg == PTR_W'(OUT_QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
            end
        end
        if (rd_en) begin
            if (rd_ptr_reg == PTR_W'(OUT_QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            end
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
